// File: hw/rtl/efr_pkg.sv
// shared types, constants and the crc step for the escaped frame receiver
package efr_pkg;

  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  // register indexes, taken from paddr[3:2]
  localparam logic [1:0] REG_CRC_ENABLE    = 2'd0;
  localparam logic [1:0] REG_BOUNDARY_BYTE = 2'd1;
  localparam logic [1:0] REG_ESCAPE_BYTE   = 2'd2;
  localparam logic [1:0] REG_ESCAPE_MASK   = 2'd3;

  localparam logic        RST_CRC_ENABLE    = 1'b1;
  localparam logic [7:0]  RST_BOUNDARY_BYTE = 8'd126;
  localparam logic [7:0]  RST_ESCAPE_BYTE   = 8'd125;
  localparam logic [7:0]  RST_ESCAPE_MASK   = 8'd32;

  localparam logic [15:0] CRC_POLY  = 16'hA001;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    KIND_DATA     = 2'd0,
    KIND_DATA_END = 2'd1,
    KIND_END      = 2'd2,
    KIND_ABORT    = 2'd3
  } kind_t;

  typedef struct packed {
    logic       crc_enable;
    logic [7:0] boundary_byte;
    logic [7:0] escape_byte;
    logic [7:0] escape_mask;
  } cfg_t;

  // reflected crc-16, one byte, lsb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: hw/rtl/efr_if.sv
// valid/ready channel interfaces for line bytes and results
interface efr_line_if;
  logic       valid;
  logic       ready;
  logic [7:0] line_byte;

  modport source (output valid, output line_byte, input ready);
  modport sink (input valid, input line_byte, output ready);
endinterface

interface efr_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  data;
  logic [14:0] byte_index;
  logic [7:0]  command;
  logic [14:0] length;
  logic        is_request;
  logic        crc_ok;

  modport source (output valid, output kind, output data, output byte_index,
                  output command, output length, output is_request, output crc_ok,
                  input ready);
  modport sink (input valid, input kind, input data, input byte_index,
                input command, input length, input is_request, input crc_ok,
                output ready);
endinterface

// File: hw/rtl/efr_regs.sv
// apb configuration registers
module efr_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [efr_pkg::ADDR_W-1:0] paddr,
  input  logic [efr_pkg::DATA_W-1:0] pwdata,
  output logic [efr_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output efr_pkg::cfg_t              cfg
);
  import efr_pkg::*;

  logic       wr;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.crc_enable    <= RST_CRC_ENABLE;
      cfg.boundary_byte <= RST_BOUNDARY_BYTE;
      cfg.escape_byte   <= RST_ESCAPE_BYTE;
      cfg.escape_mask   <= RST_ESCAPE_MASK;
    end else if (wr) begin
      unique case (idx)
        REG_CRC_ENABLE:    cfg.crc_enable    <= pwdata[0];
        REG_BOUNDARY_BYTE: cfg.boundary_byte <= pwdata[7:0];
        REG_ESCAPE_BYTE:   cfg.escape_byte   <= pwdata[7:0];
        REG_ESCAPE_MASK:   cfg.escape_mask   <= pwdata[7:0];
        default:           ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CRC_ENABLE:    prdata = {{(DATA_W-1){1'b0}}, cfg.crc_enable};
      REG_BOUNDARY_BYTE: prdata = {{(DATA_W-8){1'b0}}, cfg.boundary_byte};
      REG_ESCAPE_BYTE:   prdata = {{(DATA_W-8){1'b0}}, cfg.escape_byte};
      REG_ESCAPE_MASK:   prdata = {{(DATA_W-8){1'b0}}, cfg.escape_mask};
      default:           prdata = '0;
    endcase
  end

endmodule

// File: hw/rtl/escaped_frame_receiver_crc16.sv
// top level: byte-stuffed frame receiver with crc-16 check
//
//  channel  | dir | handshake        | payload
//  ---------+-----+------------------+--------------------------------------------
//  line     | in  | valid/ready      | line_byte[7:0]
//  result   | out | valid/ready      | kind, data, byte_index, command, length,
//           |     |                  | is_request, crc_ok
//  apb      | in  | psel/penable     | paddr[3:0], pwdata/prdata 32b, pready high
//
// one line byte per cycle sustained while result is not stalled; a byte that makes
// a result first sits in the input register, then the unescape/parse/crc pass loads
// the result register from it. the crc is a byte-wide unrolled xor network, so the
// frame state loop closes combinationally.
// reset is synchronous: frame state cleared, crc at all ones, registers at defaults.
// a byte that makes a result waits in the input register while result is
// stalled; bytes that make no result move on regardless.
module escaped_frame_receiver_crc16 (
  input  logic                       clk,
  input  logic                       rst,
  efr_line_if.sink                   line,
  efr_result_if.source               result,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [efr_pkg::ADDR_W-1:0] paddr,
  input  logic [efr_pkg::DATA_W-1:0] pwdata,
  output logic [efr_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import efr_pkg::*;

  cfg_t cfg;

  efr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_fire;
  logic       out_free;

  // frame state
  logic [15:0] byte_count, byte_count_next;
  logic        pending, pending_next;
  logic        long_header, long_header_next;
  logic [14:0] ann_len, ann_len_next;
  logic [7:0]  cur_cmd, cur_cmd_next;
  logic [15:0] crc, crc_next;

  // result of this byte
  logic        res_valid;
  kind_t       res_kind;
  logic [7:0]  res_data;
  logic [14:0] res_index;
  logic        res_ok;

  // output register
  logic        out_valid;
  kind_t       out_kind;
  logic [7:0]  out_data;
  logic [14:0] out_index;
  logic [7:0]  out_cmd;
  logic [14:0] out_len;
  logic        out_ok;

  // parse temporaries
  logic [7:0]  b;
  logic        hl_long;
  logic        is_payload;
  logic [15:0] crc_base;
  logic [15:0] pidx;
  logic [15:0] count_inc;
  logic [15:0] end_at;

  assign out_free   = !out_valid || result.ready;
  assign s1_fire    = s1_valid && (!res_valid || out_free);
  assign line.ready = !s1_valid || s1_fire;

  always_comb begin
    byte_count_next  = byte_count;
    pending_next     = pending;
    long_header_next = long_header;
    ann_len_next     = ann_len;
    cur_cmd_next     = cur_cmd;
    crc_next         = crc;
    res_valid        = 1'b0;
    res_kind         = KIND_DATA;
    res_data         = 8'h00;
    res_index        = 15'd0;
    res_ok           = 1'b0;
    b                = pending ? (s1_byte ^ cfg.escape_mask) : s1_byte;
    hl_long          = long_header;
    is_payload       = 1'b0;
    crc_base         = crc;
    pidx             = 16'd0;
    count_inc        = (byte_count == COUNT_MAX) ? byte_count : byte_count + 16'd1;
    end_at           = 16'd0;

    if (s1_byte == cfg.escape_byte) begin
      // escape wins over everything, also a repeated escape
      pending_next = 1'b1;
    end else if (!pending && (b == cfg.boundary_byte)) begin
      // unescaped boundary: abort if a frame was under way
      pending_next    = 1'b0;
      byte_count_next = 16'd0;
      if (byte_count != 16'd0) begin
        res_valid = 1'b1;
        res_kind  = KIND_ABORT;
      end
    end else begin
      pending_next = 1'b0;
      if (byte_count == 16'd0) begin
        cur_cmd_next = b;
        if (cfg.crc_enable) begin
          crc_base = CRC_INIT;
        end
      end else if (byte_count == 16'd1) begin
        // length byte, top bit selects the 15-bit form
        long_header_next = b[7];
        hl_long          = b[7];
        ann_len_next     = b[7] ? {b[6:0], 8'h00} : {7'b0, b};
      end else if ((byte_count == 16'd2) && long_header) begin
        ann_len_next = ann_len + {7'b0, b};
      end else begin
        pidx       = byte_count - (long_header ? 16'd3 : 16'd2);
        is_payload = pidx < {1'b0, ann_len};
      end

      if (cfg.crc_enable) begin
        crc_next = crc_byte(crc_base, b);
      end

      end_at = {1'b0, ann_len_next} + (hl_long ? 16'd3 : 16'd2)
             + (cfg.crc_enable ? 16'd2 : 16'd0);

      if (count_inc == end_at) begin
        byte_count_next = 16'd0;
        res_valid       = 1'b1;
        res_ok          = cfg.crc_enable ? (crc_next == 16'd0) : 1'b1;
        if (is_payload) begin
          res_kind  = KIND_DATA_END;
          res_data  = b;
          res_index = pidx[14:0];
        end else begin
          res_kind = KIND_END;
        end
      end else begin
        byte_count_next = count_inc;
        if (is_payload) begin
          res_valid = 1'b1;
          res_kind  = KIND_DATA;
          res_data  = b;
          res_index = pidx[14:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      out_valid   <= 1'b0;
      byte_count  <= 16'd0;
      pending     <= 1'b0;
      long_header <= 1'b0;
      ann_len     <= 15'd0;
      cur_cmd     <= 8'h00;
      crc         <= CRC_INIT;
    end else begin
      if (line.valid && line.ready) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end

      if (s1_fire) begin
        byte_count  <= byte_count_next;
        pending     <= pending_next;
        long_header <= long_header_next;
        ann_len     <= ann_len_next;
        cur_cmd     <= cur_cmd_next;
        crc         <= crc_next;
      end

      if (s1_fire && res_valid) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (line.valid && line.ready) begin
      s1_byte <= line.line_byte;
    end
    if (s1_fire && res_valid) begin
      out_kind  <= res_kind;
      out_data  <= res_data;
      out_index <= res_index;
      out_cmd   <= cur_cmd_next;
      out_len   <= ann_len_next;
      out_ok    <= res_ok;
    end
  end

  assign result.valid      = out_valid;
  assign result.kind       = out_kind;
  assign result.data       = out_data;
  assign result.byte_index = out_index;
  assign result.command    = out_cmd;
  assign result.length     = out_len;
  assign result.is_request = out_cmd[7];
  assign result.crc_ok     = out_ok;

endmodule

// File: hw/rtl/efr_checker.sv
// port-level checks on the frame receiver, bound to the top level
module efr_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  kind,
  input logic [7:0]  data,
  input logic [14:0] byte_index,
  input logic [7:0]  command,
  input logic [14:0] length,
  input logic        is_request,
  input logic        crc_ok
);
  import efr_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(kind) && $stable(data)
      && $stable(byte_index) && $stable(command) && $stable(length) && $stable(crc_ok)))
    else $error("stalled result changed");

  a_req: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_request == command[7]))
    else $error("is_request differs from command top bit");

  a_nodata: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (kind == KIND_END || kind == KIND_ABORT)) |-> (data == 8'h00 && byte_index == 15'd0))
    else $error("non-data result carries data");

  a_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (kind == KIND_DATA || kind == KIND_ABORT)) |-> !crc_ok)
    else $error("crc_ok set outside a packet end");

  a_idx: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (kind == KIND_DATA || kind == KIND_DATA_END)) |-> (byte_index < length))
    else $error("payload index beyond announced length");

endmodule

bind escaped_frame_receiver_crc16 efr_checker u_efr_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .kind       (result.kind),
  .data       (result.data),
  .byte_index (result.byte_index),
  .command    (result.command),
  .length     (result.length),
  .is_request (result.is_request),
  .crc_ok     (result.crc_ok)
);
